>>> src/cpf_pkg.sv
package cpf_pkg;

    // request kinds carried from the front to the back
    localparam logic [1:0] C_KIND_HDR = 2'd0;
    localparam logic [1:0] C_KIND_PAY = 2'd1;
    localparam logic [1:0] C_KIND_ERR = 2'd2;

    // configuration register indexes
    localparam logic C_REG_START = 1'b0;
    localparam logic C_REG_END   = 1'b1;

    // longest payload a header may announce
    localparam logic [15:0] C_MAX_PAYLOAD = 16'hFFFF;

    // one queued request, already checked and with its checksum worked out
    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic [15:0] cmd;
        logic [7:0]  dev;
        logic [15:0] len;
        logic [7:0]  pbyte;
        logic [15:0] csum;
    } t_job;

    // 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[16] ? (t[15:0] + 16'd1) : t[15:0];
    endfunction

endpackage

>>> src/cpf_front.sv
module cpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_req_type,
    input  logic [15:0]    i_command,
    input  logic [7:0]     i_device,
    input  logic [15:0]    i_data_len,
    input  logic [7:0]     i_payload_byte,
    input  logic           i_full,
    output logic           o_push,
    output cpf_pkg::t_job  o_job
);
    import cpf_pkg::*;

    logic        r_open, n_open;
    logic [15:0] r_remain, n_remain;
    logic [15:0] r_sum, n_sum;
    logic        r_odd, n_odd;
    logic [7:0]  r_held, n_held;

    logic        accept;
    logic [15:0] len_sat;
    logic [15:0] hdr_sum;
    logic [15:0] hdr_fin_sum;
    logic [15:0] pay_word;
    logic [15:0] pay_sum;
    logic [15:0] remain_dec;
    t_job        job;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // header words: length then command, each read low byte first
    assign len_sat     = (i_data_len > C_MAX_PAYLOAD) ? C_MAX_PAYLOAD : i_data_len;
    assign hdr_sum     = oc_add({len_sat[7:0], len_sat[15:8]}, {i_command[7:0], i_command[15:8]});
    assign hdr_fin_sum = oc_add(hdr_sum, {8'h00, i_device});

    // payload word: pairs with the held byte, or stands alone zero-padded
    assign pay_word   = r_odd ? {i_payload_byte, r_held} : {8'h00, i_payload_byte};
    assign pay_sum    = oc_add(r_sum, pay_word);
    assign remain_dec = r_remain - 16'd1;

    // classify the request and work out the next packet state
    always_comb begin
        n_open   = r_open;
        n_remain = r_remain;
        n_sum    = r_sum;
        n_odd    = r_odd;
        n_held   = r_held;
        job       = '0;
        job.cmd   = i_command;
        job.dev   = i_device;
        job.len   = len_sat;
        job.pbyte = i_payload_byte;
        if (!i_req_type) begin
            job.kind = C_KIND_HDR;
            job.fin  = (len_sat == 16'd0);
            job.csum = ~hdr_fin_sum;
            n_open   = (len_sat != 16'd0);
            n_remain = len_sat;
            n_sum    = (len_sat == 16'd0) ? 16'd0 : hdr_sum;
            n_odd    = (len_sat != 16'd0);
            n_held   = (len_sat == 16'd0) ? 8'h00 : i_device;
        end else if (!r_open) begin
            job.kind  = C_KIND_ERR;
            job.pbyte = 8'h00;
        end else begin
            job.kind = C_KIND_PAY;
            job.fin  = (remain_dec == 16'd0);
            job.csum = ~pay_sum;
            n_remain = remain_dec;
            if (remain_dec == 16'd0) begin
                n_open = 1'b0;
                n_sum  = 16'd0;
                n_odd  = 1'b0;
                n_held = 8'h00;
            end else if (r_odd) begin
                n_sum  = pay_sum;
                n_odd  = 1'b0;
                n_held = 8'h00;
            end else begin
                n_odd  = 1'b1;
                n_held = i_payload_byte;
            end
        end
    end

    // packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_remain <= 16'd0;
            r_sum    <= 16'd0;
            r_odd    <= 1'b0;
            r_held   <= 8'h00;
        end else if (accept) begin
            r_open   <= n_open;
            r_remain <= n_remain;
            r_sum    <= n_sum;
            r_odd    <= n_odd;
            r_held   <= n_held;
        end
    end

    assign o_push = accept;
    assign o_job  = job;

endmodule

>>> src/cpf_queue.sv
module cpf_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpf_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output cpf_pkg::t_job  o_job,
    output logic           o_empty
);
    import cpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> src/cpf_back.sv
module cpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpf_pkg::t_job  i_job,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic [7:0]     i_start_code,
    input  logic [7:0]     i_end_code,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_last_byte,
    output logic           o_err
);
    import cpf_pkg::*;

    // byte positions within a packet
    localparam logic [3:0] C_STEP_START  = 4'd0;
    localparam logic [3:0] C_STEP_ZERO0  = 4'd1;
    localparam logic [3:0] C_STEP_ZERO1  = 4'd2;
    localparam logic [3:0] C_STEP_LEN_HI = 4'd3;
    localparam logic [3:0] C_STEP_LEN_LO = 4'd4;
    localparam logic [3:0] C_STEP_CMD_HI = 4'd5;
    localparam logic [3:0] C_STEP_CMD_LO = 4'd6;
    localparam logic [3:0] C_STEP_DEV    = 4'd7;
    localparam logic [3:0] C_STEP_CK_HI  = 4'd8;
    localparam logic [3:0] C_STEP_CK_LO  = 4'd9;
    localparam logic [3:0] C_STEP_END    = 4'd10;

    logic       r_valid;
    logic [3:0] r_step, n_step;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_err;

    logic       advance;
    logic       step_last;
    logic [7:0] sel_byte;
    logic       sel_err;

    // pick the byte for the current step of the head request
    always_comb begin
        sel_byte = 8'h00;
        sel_err  = 1'b0;
        unique case (i_job.kind)
            C_KIND_ERR: begin
                sel_err   = 1'b1;
                step_last = 1'b1;
                n_step    = C_STEP_START;
            end
            C_KIND_PAY: begin
                step_last = i_job.fin ? (r_step == C_STEP_END) : 1'b1;
                n_step    = (r_step == C_STEP_START) ? C_STEP_CK_HI : r_step + 4'd1;
            end
            default: begin
                step_last = i_job.fin ? (r_step == C_STEP_END) : (r_step == C_STEP_DEV);
                n_step    = r_step + 4'd1;
            end
        endcase
        if (i_job.kind == C_KIND_PAY && r_step == C_STEP_START) begin
            sel_byte = i_job.pbyte;
        end else if (i_job.kind != C_KIND_ERR) begin
            unique case (r_step) inside
                C_STEP_START:               sel_byte = i_start_code;
                C_STEP_ZERO0, C_STEP_ZERO1: sel_byte = 8'h00;
                C_STEP_LEN_HI:              sel_byte = i_job.len[15:8];
                C_STEP_LEN_LO:              sel_byte = i_job.len[7:0];
                C_STEP_CMD_HI:              sel_byte = i_job.cmd[15:8];
                C_STEP_CMD_LO:              sel_byte = i_job.cmd[7:0];
                C_STEP_DEV:                 sel_byte = i_job.dev;
                C_STEP_CK_HI:               sel_byte = i_job.csum[15:8];
                C_STEP_CK_LO:               sel_byte = i_job.csum[7:0];
                C_STEP_END:                 sel_byte = i_end_code;
                default:                    sel_byte = 8'h00;
            endcase
        end
    end

    // move one byte into the output register whenever a request is queued and the register is free or taken
    assign advance = !i_empty && (!r_valid || i_ready);
    assign o_pop   = advance && step_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= C_STEP_START;
        end else if (advance) begin
            r_valid <= 1'b1;
            r_step  <= step_last ? C_STEP_START : n_step;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output byte register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= sel_byte;
            r_last <= (r_step == C_STEP_END);
            r_err  <= sel_err;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;
    assign o_err       = r_err;

    // an error result is a lone zero byte, never the packet end
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> (r_byte == 8'h00 && !r_last))
        else $error("malformed error result");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= C_STEP_END)
        else $error("byte step out of range");
    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == C_STEP_START))
        else $error("step not cleared after request finished");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_step == C_STEP_END) |-> o_pop)
        else $error("end code did not close the request");

endmodule

>>> src/command_packet_framer_with_checksum.sv
// channel  direction  handshake             payload
// input    in         i_valid / o_ready     i_req_type, i_command, i_device, i_data_len,
//                                           i_payload_byte
// output   out        o_valid / i_ready     o_out_byte, o_last_byte, o_err
// config   in         psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// each request is taken while the front queue has room; a payload byte yields one
// output byte, a header eight (eleven with zero length)
// the back end sends one byte a cycle while a request is queued and the output is not stalled
// a finished packet adds three bytes for the checksum and end code
// synchronous active-low reset clears packet state, the queue and both code registers
// output stalls fill the queue, after which o_ready drops; input gaps leave bytes flowing
module command_packet_framer_with_checksum #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_command,
    input  logic [7:0]  i_device,
    input  logic [15:0] i_data_len,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_err,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpf_pkg::*;

    logic [7:0] r_start_code;
    logic [7:0] r_end_code;
    logic       cfg_wr;
    logic       reg_idx;

    t_job       front_job;
    t_job       head_job;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= 8'h00;
            r_end_code   <= 8'h00;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                C_REG_START: r_start_code <= pwdata[7:0];
                C_REG_END:   r_end_code   <= pwdata[7:0];
                default:     r_end_code   <= r_end_code;
            endcase
        end
    end

    assign prdata = (reg_idx == C_REG_END) ? {24'd0, r_end_code} : {24'd0, r_start_code};

    // request classification and checksum
    cpf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_command      (i_command),
        .i_device       (i_device),
        .i_data_len     (i_data_len),
        .i_payload_byte (i_payload_byte),
        .i_full         (full),
        .o_push         (push),
        .o_job          (front_job)
    );

    // decoupling queue
    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    // byte serialiser
    cpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_start_code (r_start_code),
        .i_end_code   (r_end_code),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .o_err        (o_err)
    );

endmodule
